@@ hdl/ofpw_pkg.sv @@
package ofpw_pkg;

   localparam int FRAME_LEN   = 128;
   localparam int OVERLAP     = 32;
   localparam int NEW_SAMPLES = 96;

   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 15;
   localparam int WEIGHT_W = 16;
   localparam int VALUE_W  = 17;
   localparam int FRAME_W  = 16;
   localparam int POS_W    = 7;
   localparam int FRESH_W  = 7;
   localparam int OVL_W    = 5;
   localparam int MPY_W    = 32;
   localparam int Y_W      = 33;
   localparam int ACC_W    = 50;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [COEF_W-1:0] COEF_RESET = 15'd31130;

   localparam longint unsigned PHASE_DIV = 64'(FRAME_LEN - 1);

   typedef enum logic {
      CSR_PRE_EMPH_COEF = 1'b0,
      CSR_UNUSED        = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL,
      ST_DIFF,
      ST_WEIGHT,
      ST_PUSH
   } state_type;

   typedef struct packed {
      logic                wr_en;
      logic [OVL_W-1:0]    wr_addr;
      logic [SAMPLE_W-1:0] wr_data;
      logic [OVL_W-1:0]    rd_addr;
   } store_req_type;

   typedef logic [WEIGHT_W-1:0] win_rom_type [FRAME_LEN];

   function automatic win_rom_type build_window();
      win_rom_type       rom;
      longint unsigned   p;
      longint unsigned   x;
      longint unsigned   x2;
      longint unsigned   t;
      longint unsigned   m;
      longint            c;
      longint            w30;
      bit                neg;
      longint unsigned   one_q30;
      one_q30 = 64'h4000_0000;
      for (int i = 0; i < FRAME_LEN; i++) begin
         p = (longint'(i) << 32) / PHASE_DIV;
         neg = 1'b0;
         if (p > 64'h8000_0000) begin
            p = 64'h1_0000_0000 - p;
         end
         if (p > 64'h4000_0000) begin
            p = 64'h8000_0000 - p;
            neg = 1'b1;
         end
         x  = (p * 64'd6746518852 + 64'h8000_0000) >> 32;
         x2 = (x * x + 64'h2000_0000) >> 30;
         t  = one_q30 - x2 / 132;
         t  = one_q30 - ((x2 * t) >> 30) / 90;
         t  = one_q30 - ((x2 * t) >> 30) / 56;
         t  = one_q30 - ((x2 * t) >> 30) / 30;
         t  = one_q30 - ((x2 * t) >> 30) / 12;
         c  = longint'(one_q30) - longint'(((x2 * t) >> 30) / 2);
         if (neg) begin
            c = -c;
         end
         if (c >= 0) begin
            m   = (64'd493921239 * longint'(c)) >> 30;
            w30 = 64'sd579820585 - longint'(m);
         end else begin
            m   = (64'd493921239 * longint'(-c)) >> 30;
            w30 = 64'sd579820585 + longint'(m);
         end
         if (w30 < 0) begin
            w30 = 0;
         end
         rom[i] = WEIGHT_W'((longint'(w30) + 64'h4000) >> 15);
      end
      return rom;
   endfunction

   localparam win_rom_type WIN_ROM = build_window();

endpackage

@@ hdl/ofpw_overlap_store.sv @@
module ofpw_overlap_store (
   input  logic                           clock,
   input  logic                           reset,
   input  ofpw_pkg::store_req_type        store_req,
   output logic [ofpw_pkg::SAMPLE_W-1:0]  rd_data
);

   logic [ofpw_pkg::SAMPLE_W-1:0] mem [ofpw_pkg::OVERLAP];
   logic [ofpw_pkg::OVERLAP-1:0]  valid_ff;
   logic [ofpw_pkg::OVERLAP-1:0]  valid_in;
   logic [ofpw_pkg::SAMPLE_W-1:0] rd_data_ff;
   logic                          rd_valid_ff;
   logic                          rd_valid_in;

   always_comb begin
      valid_in = valid_ff;
      if (store_req.wr_en) begin
         valid_in[store_req.wr_addr] = 1'b1;
      end
      rd_valid_in = valid_ff[store_req.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         mem[store_req.wr_addr] <= store_req.wr_data;
      end
      rd_data_ff <= mem[store_req.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

@@ hdl/overlap_framer_preemph_window_unit.sv @@
// Overlapping speech framer with pre-emphasis and Hamming window.
// Request channel: one signed 16-bit sample per transaction (req_valid, req_stall).
// Response channel: one windowed value per transaction, tagged with frame number,
// position in the frame and a frame_last marker (rsp_valid, rsp_stall).
// Each frame is 128 positions: 32 kept from the end of the previous frame and
// 96 fresh samples. The first fresh sample of a frame yields 33 responses (the
// 32 kept positions, then itself); every other sample yields one.
// Each response goes through a four-step sequence: multiply the previous value by
// the coefficient, subtract, multiply by the window weight, round into the output
// register. A new sample is accepted only once the previous one has pushed its
// last response; a frame-start sample reads the overlap store once per kept
// position, before that position's sequence.
// The request side is taken again while the last response waits.
// The CSR port (APB-style, always ready) holds pre_emph_coef at address 0.
// Reset clears the overlap store (valid bits), counters and previous value at
// once and returns the coefficient to 31130. A stalled response holds the
// sequence in its final step; no transaction is lost.
module overlap_framer_preemph_window_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [ofpw_pkg::SAMPLE_W-1:0]  req_sample_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [ofpw_pkg::FRAME_W-1:0]          rsp_frame_number,
   output logic [ofpw_pkg::POS_W-1:0]            rsp_position,
   output logic signed [ofpw_pkg::VALUE_W-1:0]   rsp_windowed_value,
   output logic                                  rsp_frame_last,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [ofpw_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [ofpw_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [ofpw_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);

   ofpw_pkg::state_type state_ff;
   ofpw_pkg::state_type state_in;

   logic [ofpw_pkg::COEF_W-1:0]          coef_ff;
   logic [ofpw_pkg::FRESH_W-1:0]         fresh_ff;
   logic [ofpw_pkg::FRAME_W-1:0]         frame_ff;
   logic signed [ofpw_pkg::SAMPLE_W-1:0] prev_ff;
   logic signed [ofpw_pkg::SAMPLE_W-1:0] sample_ff;
   logic                                 ovl_ff;
   logic [ofpw_pkg::OVL_W-1:0]           idx_ff;
   logic [ofpw_pkg::POS_W-1:0]           pos_ff;
   logic                                 last_ff;
   logic signed [ofpw_pkg::SAMPLE_W-1:0] xs_ff;
   logic signed [ofpw_pkg::MPY_W-1:0]    prod_ff;
   logic signed [ofpw_pkg::Y_W-1:0]      y_ff;
   logic [ofpw_pkg::WEIGHT_W-1:0]        w_ff;
   logic signed [ofpw_pkg::ACC_W-1:0]    acc_ff;

   logic                                 rsp_valid_ff;
   logic [ofpw_pkg::FRAME_W-1:0]         rsp_frame_ff;
   logic [ofpw_pkg::POS_W-1:0]           rsp_pos_ff;
   logic signed [ofpw_pkg::VALUE_W-1:0]  rsp_value_ff;
   logic                                 rsp_last_ff;

   logic                                 req_accept;
   logic                                 out_load;
   logic                                 csr_write;
   logic                                 last_ovl;
   logic signed [ofpw_pkg::SAMPLE_W-1:0] cur_x;
   logic signed [ofpw_pkg::SAMPLE_W-1:0] store_rd;
   logic signed [ofpw_pkg::MPY_W-1:0]    prod_in;
   logic signed [ofpw_pkg::Y_W-1:0]      y_in;
   logic signed [ofpw_pkg::ACC_W-1:0]    acc_in;
   logic signed [ofpw_pkg::ACC_W-1:0]    rnd;
   logic signed [ofpw_pkg::ACC_W-1:0]    val;
   ofpw_pkg::store_req_type              store_req;

   ofpw_overlap_store u_store (
      .clock     (clock),
      .reset     (reset),
      .store_req (store_req),
      .rd_data   (store_rd)
   );

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == ofpw_pkg::CSR_PRE_EMPH_COEF)
                       ? ofpw_pkg::CSR_DATA_W'(coef_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= ofpw_pkg::COEF_RESET;
      end else if (csr_write && csr_paddr[2] == ofpw_pkg::CSR_PRE_EMPH_COEF) begin
         coef_ff <= csr_pwdata[ofpw_pkg::COEF_W-1:0];
      end
   end

   // outputs of the sequencer
   always_comb begin
      req_stall = 1'b1;
      out_load  = 1'b0;
      unique case (state_ff)
         ofpw_pkg::ST_IDLE: begin
            req_stall = 1'b0;
         end
         ofpw_pkg::ST_PUSH: begin
            out_load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
         end
      endcase
   end

   assign req_accept = req_valid && !req_stall;
   assign last_ovl   = idx_ff == ofpw_pkg::OVL_W'(ofpw_pkg::OVERLAP - 1);

   // next state of the sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ofpw_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = (fresh_ff == '0) ? ofpw_pkg::ST_READ : ofpw_pkg::ST_MUL;
            end
         end
         ofpw_pkg::ST_READ:   state_in = ofpw_pkg::ST_MUL;
         ofpw_pkg::ST_MUL:    state_in = ofpw_pkg::ST_DIFF;
         ofpw_pkg::ST_DIFF:   state_in = ofpw_pkg::ST_WEIGHT;
         ofpw_pkg::ST_WEIGHT: state_in = ofpw_pkg::ST_PUSH;
         ofpw_pkg::ST_PUSH: begin
            if (out_load) begin
               if (!ovl_ff) begin
                  state_in = ofpw_pkg::ST_IDLE;
               end else if (last_ovl) begin
                  state_in = ofpw_pkg::ST_MUL;
               end else begin
                  state_in = ofpw_pkg::ST_READ;
               end
            end
         end
         default: state_in = ofpw_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      store_req.wr_en   = req_accept &&
         (fresh_ff >= ofpw_pkg::FRESH_W'(ofpw_pkg::NEW_SAMPLES - ofpw_pkg::OVERLAP));
      store_req.wr_addr = ofpw_pkg::OVL_W'(fresh_ff -
         ofpw_pkg::FRESH_W'(ofpw_pkg::NEW_SAMPLES - ofpw_pkg::OVERLAP));
      store_req.wr_data = req_sample_in;
      store_req.rd_addr = idx_ff;
   end

   assign cur_x   = ovl_ff ? store_rd : sample_ff;
   assign prod_in = $signed({1'b0, coef_ff}) * prev_ff;
   assign y_in    = (ofpw_pkg::Y_W'(xs_ff) <<< 15) - ofpw_pkg::Y_W'(prod_ff);
   assign acc_in  = y_ff * $signed({1'b0, w_ff});
   assign rnd     = acc_ff + (ofpw_pkg::ACC_W'(1) <<< 29);
   assign val     = rnd >>> 30;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ofpw_pkg::ST_IDLE;
         fresh_ff     <= '0;
         frame_ff     <= '0;
         prev_ff      <= '0;
         ovl_ff       <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_accept && fresh_ff == '0) begin
            frame_ff <= frame_ff + 1'b1;
            ovl_ff   <= 1'b1;
            idx_ff   <= '0;
         end else if (req_accept) begin
            ovl_ff <= 1'b0;
         end
         if (state_ff == ofpw_pkg::ST_MUL) begin
            prev_ff <= cur_x;
         end
         if (out_load) begin
            if (ovl_ff) begin
               if (last_ovl) begin
                  ovl_ff <= 1'b0;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end else begin
               fresh_ff <= last_ff ? '0 : fresh_ff + 1'b1;
            end
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         sample_ff <= req_sample_in;
      end
      if (state_ff == ofpw_pkg::ST_MUL) begin
         prod_ff <= prod_in;
         xs_ff   <= cur_x;
         if (ovl_ff) begin
            pos_ff  <= ofpw_pkg::POS_W'(idx_ff);
            last_ff <= 1'b0;
         end else begin
            pos_ff  <= ofpw_pkg::POS_W'(ofpw_pkg::OVERLAP) + fresh_ff;
            last_ff <= fresh_ff == ofpw_pkg::FRESH_W'(ofpw_pkg::NEW_SAMPLES - 1);
         end
      end
      if (state_ff == ofpw_pkg::ST_DIFF) begin
         y_ff <= y_in;
         w_ff <= ofpw_pkg::WIN_ROM[pos_ff];
      end
      if (state_ff == ofpw_pkg::ST_WEIGHT) begin
         acc_ff <= acc_in;
      end
      if (out_load) begin
         rsp_frame_ff <= frame_ff;
         rsp_pos_ff   <= pos_ff;
         rsp_value_ff <= val[ofpw_pkg::VALUE_W-1:0];
         rsp_last_ff  <= last_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_frame_number   = rsp_frame_ff;
   assign rsp_position       = rsp_pos_ff;
   assign rsp_windowed_value = rsp_value_ff;
   assign rsp_frame_last     = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_accept_starts_work: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff != ofpw_pkg::ST_IDLE)
      else $error("accepted transaction started no work");

   a_last_at_frame_end: assert property (@(posedge clock) disable iff (reset)
      out_load && last_ff |-> pos_ff == ofpw_pkg::POS_W'(ofpw_pkg::FRAME_LEN - 1))
      else $error("frame_last away from final position");

   a_fresh_in_range: assert property (@(posedge clock) disable iff (reset)
      fresh_ff < ofpw_pkg::FRESH_W'(ofpw_pkg::NEW_SAMPLES))
      else $error("fresh count out of range");

   a_store_read_first: assert property (@(posedge clock) disable iff (reset)
      state_ff == ofpw_pkg::ST_MUL && ovl_ff |-> $past(state_ff) == ofpw_pkg::ST_READ)
      else $error("overlap position used without store read");
`endif

endmodule
